/* rtl/core/age_hop_weighted_vc_arbiter_core_assert.svh */
// Assertion macros shared by the arbiter RTL.
`ifndef AGE_HOP_WEIGHTED_VC_ARBITER_CORE_ASSERT_SVH
`define AGE_HOP_WEIGHTED_VC_ARBITER_CORE_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define AHW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Next-cycle implication.
`define AHW_NEXT(lbl, ante, cons, msg) \
	`AHW_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* rtl/core/ahw_pkg.sv */
package ahw_pkg;

	localparam int CHANNELS  = 4;
	localparam int WAIT_BITS = 16;
	localparam int CH_BITS   = $clog2(CHANNELS);

	// Fixed word field widths
	localparam int IN_CH     = 4;
	localparam int HOP_W     = 8;
	localparam int MASK_W    = IN_CH;
	localparam int HOPS_W    = IN_CH * HOP_W;
	localparam int GRANT_W   = 2;

	// Priority = wait count + hop excess, one carry bit
	localparam int PRIO_BITS = ((WAIT_BITS > HOP_W) ? WAIT_BITS : HOP_W) + 1;

	// Configuration register map
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_ARB_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOP_USE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOP_THRESH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CORE_PORT  = 2'd3;

	localparam logic MODE_SEQ      = 1'b0;
	localparam logic MODE_ADAPTIVE = 1'b1;

	typedef logic [CH_BITS-1:0]   chan_idx_t;
	typedef logic [PRIO_BITS-1:0] prio_t;

	// Shared control into every lane
	typedef struct packed {
		logic             upd;       // word accepted this cycle
		logic             inc_en;    // adaptive aging active
		logic             hop_use;
		logic [HOP_W-1:0] hop_thresh;
	} lane_ctl_t;

endpackage

/* rtl/core/ahw_if.sv */
interface ahw_in_if import ahw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] nonempty_mask;
	logic [HOPS_W-1:0] head_hops;

	modport source (output valid, output nonempty_mask, output head_hops, input ready);
	modport sink   (input valid, input nonempty_mask, input head_hops, output ready);
endinterface

interface ahw_out_if import ahw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [GRANT_W-1:0] grant_channel;
	logic               grant_valid;

	modport source (output valid, output grant_channel, output grant_valid, input ready);
	modport sink   (input valid, input grant_channel, input grant_valid, output ready);
endinterface

/* rtl/core/ahw_lane.sv */
module ahw_lane import ahw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  lane_ctl_t        ctl,
	input  logic             busy,
	input  logic [HOP_W-1:0] hop,
	input  logic             clr,
	output prio_t            prio
);

	localparam logic [WAIT_BITS-1:0] WAIT_MAX = '1;

	logic [WAIT_BITS-1:0] wait_q;
	logic [WAIT_BITS-1:0] wait_inc;
	logic [HOP_W-1:0]     excess;

	// saturating age step, only for non-empty channels
	assign wait_inc = (ctl.inc_en && busy && wait_q != WAIT_MAX) ? wait_q + 1'b1 : wait_q;

	assign excess = (ctl.hop_use && hop > ctl.hop_thresh) ? hop - ctl.hop_thresh : '0;

	assign prio = PRIO_BITS'(wait_inc) + PRIO_BITS'(excess);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q <= '0;
		end else if (ctl.upd) begin
			if (clr) begin
				wait_q <= '0;
			end else begin
				wait_q <= wait_inc;
			end
		end
	end

endmodule

/* rtl/core/ahw_merge.sv */
module ahw_merge import ahw_pkg::*; (
	input  logic [CHANNELS-1:0] busy,
	input  prio_t               prio [CHANNELS],
	output chan_idx_t           pick
);

	// strict greater-than keeps the lowest index on ties; all empty -> 0
	always_comb begin
		logic  found;
		prio_t best;
		found = 1'b0;
		best  = '0;
		pick  = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (busy[i] && (!found || prio[i] > best)) begin
				found = 1'b1;
				best  = prio[i];
				pick  = CH_BITS'(i);
			end
		end
	end

endmodule

/* rtl/core/age_hop_weighted_vc_arbiter_core.sv */
// Age/hop weighted virtual channel arbiter, one router input port.
// in_ch : one word per arbitration tick: non-empty VC mask and packed
//         8-bit head flit hop counts (channel i in bits 8i+7..8i).
// out_ch: one word per input word: grant_channel and grant_valid.
// cfg   : cfg_we/cfg_index/cfg_wdata write arb_mode, hop_use, hop threshold,
//         core_port; write only while no word is in flight.
// Throughput: one word per cycle when not stalled. Aging, per-lane
// priority add and the lowest-index max scan over the lanes all finish
// in the accept cycle, so wait counts are current for a word in the very
// next cycle. Grant registered at accept, held in the output register.
// Stall: in_ch.ready = output register empty or being drained, so a
// waiting grant blocks only the next word, and flow resumes the same
// cycle the sink takes it.
// Reset: arb_mode adaptive, hop_use 0, hop threshold 0, core_port 0, all
// wait counts and the tick counter zero, output register empty.
module age_hop_weighted_vc_arbiter_core import ahw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	ahw_in_if.sink                in_ch,
	ahw_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	`include "age_hop_weighted_vc_arbiter_core_assert.svh"

	// config registers
	logic             arb_mode_q;
	logic             hop_use_q;
	logic [HOP_W-1:0] hop_thresh_q;
	logic             core_port_q;

	chan_idx_t        tick_q;
	logic             in_fire;

	logic [CHANNELS-1:0] busy;
	prio_t               prio [CHANNELS];
	chan_idx_t           merge_pick;
	chan_idx_t           pick;
	lane_ctl_t           lane_ctl;

	logic               out_valid_q;
	logic [GRANT_W-1:0] out_chan_q;
	logic               out_gv_q;

	logic               core_fire;
	logic               adapt_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arb_mode_q   <= MODE_ADAPTIVE;
			hop_use_q    <= 1'b0;
			hop_thresh_q <= '0;
			core_port_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ARB_MODE:   arb_mode_q   <= cfg_wdata[0];
				REG_HOP_USE:    hop_use_q    <= cfg_wdata[0];
				REG_HOP_THRESH: hop_thresh_q <= cfg_wdata[HOP_W-1:0];
				REG_CORE_PORT:  core_port_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// output register frees up in the same cycle it is drained
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_fire     = in_ch.valid && in_ch.ready;

	assign lane_ctl.upd        = in_fire;
	assign lane_ctl.inc_en     = (arb_mode_q == MODE_ADAPTIVE) && !core_port_q;
	assign lane_ctl.hop_use    = hop_use_q;
	assign lane_ctl.hop_thresh = hop_thresh_q;

	// one lane per VC; channels past the word's fields stay empty
	for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
		logic [HOP_W-1:0] hop;
		if (i < IN_CH) begin : g_live
			assign busy[i] = in_ch.nonempty_mask[i];
			assign hop     = in_ch.head_hops[HOP_W*i +: HOP_W];
		end else begin : g_idle
			assign busy[i] = 1'b0;
			assign hop     = '0;
		end

		ahw_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lane_ctl),
			.busy   (busy[i]),
			.hop    (hop),
			.clr    (pick == CH_BITS'(i)),
			.prio   (prio[i])
		);
	end

	ahw_merge u_merge (
		.busy (busy),
		.prio (prio),
		.pick (merge_pick)
	);

	// core port wins, then rotation, then weighted pick
	always_comb begin
		if (core_port_q) begin
			pick = '0;
		end else if (arb_mode_q == MODE_SEQ) begin
			pick = tick_q;
		end else begin
			pick = merge_pick;
		end
	end

	// tick counter runs every word in every mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (in_fire) begin
			if (tick_q == CH_BITS'(CHANNELS - 1)) begin
				tick_q <= '0;
			end else begin
				tick_q <= tick_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_chan_q <= GRANT_W'(pick);
			out_gv_q   <= busy[pick];
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.grant_channel = out_chan_q;
	assign out_ch.grant_valid   = out_gv_q;

	// accepted words that the checks below look at
	assign core_fire  = in_fire && core_port_q;
	assign adapt_fire = in_fire && lane_ctl.inc_en && (|busy);

	`AHW_NEXT(a_core_grants_zero, core_fire, out_chan_q == '0, "core port grant not zero")
	`AHW_NEXT(a_adaptive_grant_live, adapt_fire, out_gv_q, "adaptive grant on empty channel")
	`AHW_ASSERT(a_tick_range, tick_q <= CH_BITS'(CHANNELS - 1), "tick counter out of range")

endmodule

/* dv/tb_age_hop_weighted_vc_arbiter_core.sv */
module tb_age_hop_weighted_vc_arbiter_core;
	import ahw_pkg::*;

	// One grant word as the arbiter returns it
	typedef struct packed {
		chan_idx_t chan;
		logic      vld;
	} grant_t;

	logic clk;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	ahw_in_if  in_if();
	ahw_out_if out_if();

	age_hop_weighted_vc_arbiter_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_if),
		.out_ch    (out_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copy of the arbiter: config registers, per-VC age and the
	// rotation tick. Age and tick advance once per accepted input word.
	logic                 cfg_mode;
	logic                 cfg_hop_use;
	logic [HOP_W-1:0]     cfg_hop_thresh;
	logic                 cfg_core;
	logic [WAIT_BITS-1:0] age_q [CHANNELS];
	chan_idx_t            tick_q;

	grant_t grants_due[$];   // grants predicted, not yet seen on out_ch
	int     mismatch_cnt;
	int     send_idle_pct;   // chance per cycle that the sender holds back
	int     recv_idle_pct;   // chance per cycle that the sink drops ready
	int     hold_left;       // cycles of forced sink stall still to run

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Runaway guard, far beyond the slowest legal run
	initial begin
		#5000000;
		$display("tb_age_hop_weighted_vc_arbiter_core: errors");
		$finish;
	end

	// Predict one grant and advance the shadow state, same order as the
	// hardware: aging first (adaptive only), then scan, then clear the winner.
	function automatic grant_t arbitrate(logic [MASK_W-1:0] mask, logic [HOPS_W-1:0] hops);
		chan_idx_t        win;
		prio_t            best;
		prio_t            score;
		logic [HOP_W-1:0] h;
		logic [HOP_W-1:0] excess;
		logic             found;
		grant_t           g;
		win   = '0;
		best  = '0;
		found = 1'b0;
		if (cfg_core) begin
			win = '0;
		end else if (cfg_mode == MODE_SEQ) begin
			win = tick_q;
		end else begin
			for (int i = 0; i < CHANNELS; i++)
				if (mask[i] && age_q[i] != '1)
					age_q[i] = age_q[i] + 1'b1;
			for (int i = 0; i < CHANNELS; i++) begin
				if (!mask[i])
					continue;
				h      = hops[HOP_W*i +: HOP_W];
				excess = (cfg_hop_use && h > cfg_hop_thresh) ? h - cfg_hop_thresh : '0;
				score  = prio_t'(age_q[i]) + prio_t'(excess);
				// strict compare keeps the lowest index on a tie
				if (!found || score > best) begin
					found = 1'b1;
					best  = score;
					win   = chan_idx_t'(i);
				end
			end
		end
		age_q[win] = '0;
		tick_q     = tick_q + 1'b1;
		g.chan = win;
		g.vld  = mask[win];
		return g;
	endfunction

	// Sink side: random ready, or a forced stall while hold_left runs down
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_if.ready = 1'b0;
			hold_left    = hold_left - 1;
		end else begin
			out_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Grant checker: each word taken from out_ch against the oldest prediction
	always @(posedge clk) begin
		grant_t exp_g;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (grants_due.size() == 0) begin
				$error("grant word with no prediction pending: chan %0d vld %0b",
					out_if.grant_channel, out_if.grant_valid);
				mismatch_cnt++;
			end else begin
				exp_g = grants_due.pop_front();
				if (out_if.grant_channel !== exp_g.chan) begin
					$error("grant_channel: expected %0d, got %0d", exp_g.chan,
						out_if.grant_channel);
					mismatch_cnt++;
				end
				if (out_if.grant_valid !== exp_g.vld) begin
					$error("grant_valid: expected %0b, got %0b", exp_g.vld,
						out_if.grant_valid);
					mismatch_cnt++;
				end
			end
		end
	end

	// Offer one input word; entered and left at a falling edge. The predictor
	// runs at the edge where the word is taken.
	task automatic send_word(input logic [MASK_W-1:0] mask, input logic [HOPS_W-1:0] hops);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_if.valid         = 1'b0;
			in_if.nonempty_mask = MASK_W'($urandom);
			in_if.head_hops     = $urandom;
			@(negedge clk);
		end
		in_if.valid         = 1'b1;
		in_if.nonempty_mask = mask;
		in_if.head_hops     = hops;
		do @(posedge clk); while (!in_if.ready);
		grants_due.push_back(arbitrate(mask, hops));
		@(negedge clk);
	endtask

	// Stop offering and let every predicted grant come out, then wait on
	// so that config writes stay clear of the pipeline.
	task automatic settle();
		in_if.valid = 1'b0;
		while (grants_due.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_ARB_MODE:   cfg_mode       = data[0];
			REG_HOP_USE:    cfg_hop_use    = data[0];
			REG_HOP_THRESH: cfg_hop_thresh = data[HOP_W-1:0];
			REG_CORE_PORT:  cfg_core       = data[0];
			default: ;
		endcase
	endtask

	// Full register set, only once the block is idle
	task automatic set_config(input logic mode, input logic hop_use,
			input logic [HOP_W-1:0] level, input logic core);
		settle();
		write_reg(REG_ARB_MODE, CFG_DATA_W'(mode));
		write_reg(REG_HOP_USE, CFG_DATA_W'(hop_use));
		write_reg(REG_HOP_THRESH, CFG_DATA_W'(level));
		write_reg(REG_CORE_PORT, CFG_DATA_W'(core));
	endtask

	// Reset defaults: adaptive, no hop term. Empty mask, full-mask ties,
	// lone requesters and aging that breaks ties on the next tick.
	task automatic test_adaptive_defaults();
		send_word(4'h0, 32'h0000_0000);
		send_word(4'hF, 32'hFFFF_FFFF);
		send_word(4'hF, 32'hFFFF_FFFF);
		send_word(4'b1000, 32'h0000_0000);
		send_word(4'b0110, 32'hFF00_00FF);
		send_word(4'hF, 32'h0102_0304);
	endtask

	// Hop excess on: threshold at both extremes and right at the hop value
	task automatic test_hop_weighting();
		set_config(MODE_ADAPTIVE, 1'b1, 8'd0, 1'b0);
		send_word(4'hF, 32'hFF00_0001);
		send_word(4'hF, 32'h0000_FF00);
		set_config(MODE_ADAPTIVE, 1'b1, 8'hFF, 1'b0);
		send_word(4'hF, 32'hFFFF_FFFF);
		set_config(MODE_ADAPTIVE, 1'b1, 8'h80, 1'b0);
		send_word(4'hF, 32'h8081_7F80);
		send_word(4'b1010, 32'hFF80_0081);
	endtask

	// Rotation: tick keeps running across config writes; an empty slot
	// still gets the grant, with grant_valid low.
	task automatic test_sequence_mode();
		set_config(MODE_SEQ, 1'b0, 8'd0, 1'b0);
		send_word(4'b0101, 32'h1234_5678);
		send_word(4'b0101, 32'h1234_5678);
		send_word(4'h0, 32'hFFFF_FFFF);
		send_word(4'hF, 32'h0000_0000);
		send_word(4'b1000, 32'hAAAA_5555);
	endtask

	// Core port forces VC0 in both modes; grant_valid follows mask bit 0
	task automatic test_core_port();
		set_config(MODE_ADAPTIVE, 1'b1, 8'd0, 1'b1);
		send_word(4'b1110, 32'hFFFF_FFFF);
		send_word(4'b0001, 32'h0000_0000);
		set_config(MODE_SEQ, 1'b0, 8'd0, 1'b1);
		send_word(4'h0, 32'h5555_AAAA);
		send_word(4'hF, 32'hFFFF_FFFF);
	endtask

	// Sink frozen for a long stretch while words keep coming: the output
	// register fills and in_ch.ready has to drop until the sink returns.
	task automatic test_backpressure();
		int saved_idle;
		saved_idle    = send_idle_pct;
		send_idle_pct = 0;
		settle();
		hold_left = 300;
		for (int n = 0; n < 40; n++)
			send_word(4'hF, $urandom);
		send_idle_pct = saved_idle;
	endtask

	// Busy masks dominate so ages climb; hop bytes either fully random or
	// bunched near the threshold so the excess term decides often.
	task automatic test_random(input int words);
		int               sent;
		int               chunk;
		logic [MASK_W-1:0] mask;
		logic [HOPS_W-1:0] hops;
		logic [HOP_W-1:0]  level;
		sent = 0;
		while (sent < words) begin
			case ($urandom_range(0, 3))
				0:       level = 8'd0;
				1:       level = 8'hFF;
				default: level = HOP_W'($urandom);
			endcase
			set_config(($urandom_range(0, 3) != 0), 1'($urandom_range(0, 1)), level,
				($urandom_range(0, 9) == 0));
			chunk = $urandom_range(20, 80);
			for (int n = 0; n < chunk && sent < words; n++) begin
				case ($urandom_range(0, 9))
					0:          mask = '0;
					1, 2, 3, 4: mask = '1;
					default:    mask = MASK_W'($urandom);
				endcase
				hops = $urandom;
				if ($urandom_range(0, 2) == 0)
					for (int i = 0; i < IN_CH; i++)
						hops[HOP_W*i +: HOP_W] = level + HOP_W'($urandom_range(0, 6)) - 8'd3;
				send_word(mask, hops);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_wdata           = '0;
		in_if.valid         = 1'b0;
		in_if.nonempty_mask = '0;
		in_if.head_hops     = '0;
		out_if.ready        = 1'b0;
		hold_left           = 0;
		mismatch_cnt        = 0;
		send_idle_pct       = 31;
		recv_idle_pct       = 49;
		// shadow reset values
		cfg_mode       = MODE_ADAPTIVE;
		cfg_hop_use    = 1'b0;
		cfg_hop_thresh = '0;
		cfg_core       = 1'b0;
		tick_q         = '0;
		for (int i = 0; i < CHANNELS; i++)
			age_q[i] = '0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Ages can't reach saturation here: a busy VC wins once its age
		// passes the largest hop excess, so it tops out near 256.
		test_adaptive_defaults();
		test_hop_weighting();
		test_sequence_mode();
		test_core_port();
		test_random(630);
		test_backpressure();

		send_idle_pct = 49;
		recv_idle_pct = 31;
		test_random(630);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(630);

		settle();
		repeat (3) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("tb_age_hop_weighted_vc_arbiter_core: clean");
		end else begin
			$display("tb_age_hop_weighted_vc_arbiter_core: errors");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/ahw_pkg.sv
rtl/core/ahw_if.sv
rtl/core/ahw_lane.sv
rtl/core/ahw_merge.sv
rtl/core/age_hop_weighted_vc_arbiter_core.sv
dv/tb_age_hop_weighted_vc_arbiter_core.sv
